FILE: hdl/rgb_sharpen_3x3_unit_assert.svh
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_unit assertion macros
// concurrent checks used by the sharpen unit top file
// ----------------------------------------------------------------------------
`ifndef RGB_SHARPEN_3X3_UNIT_ASSERT_SVH
`define RGB_SHARPEN_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define RSH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_sharpen_3x3_unit: assertion failed");

// next-cycle implication
`define RSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_sharpen_3x3_unit: assertion failed");

`endif

FILE: hdl/rsh_pkg.sv
// ----------------------------------------------------------------------------
// rsh_pkg
// shared constants and types of the rgb 3x3 sharpen unit
// ----------------------------------------------------------------------------
`default_nettype none

package rsh_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int CW1          = COL_W + 1;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 12;
    localparam int PIX_W        = 24;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int MIN_DIM      = 3;
    localparam int WIDTH_RESET  = 600;
    localparam int HEIGHT_RESET = 400;

    // register index codes, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // effective frame geometry
    typedef struct packed {
        logic [COL_W:0]        width;
        logic [HEIGHT_W-1:0]   height;
    } t_cfg;

    // per-word control travelling with the window update
    typedef struct packed {
        logic valid;
        logic emit;
        logic interior;
        logic last;
    } t_ctl;

    // result word ready to be registered at the output
    typedef struct packed {
        logic valid;
        logic last;
        t_pix rgb;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/rsh_ram.sv
// ----------------------------------------------------------------------------
// rsh_ram
// generic simple dual-port ram, read-first, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rsh_cfg.sv
// ----------------------------------------------------------------------------
// rsh_cfg
// apb register file holding frame width and height, with range clamping
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rsh_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rsh_pkg::APB_DW-1:0]  pwdata,
    output logic      [rsh_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output rsh_pkg::t_cfg                    o_cfg
);
    import rsh_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(WIDTH_RESET);
            r_height <= HEIGHT_W'(HEIGHT_RESET);
        end else if (wr) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (32'(r_width) > MAX_WIDTH) begin
            o_cfg.width = CW1'(MAX_WIDTH);
        end else if (32'(r_width) < MIN_DIM) begin
            o_cfg.width = CW1'(MIN_DIM);
        end else begin
            o_cfg.width = CW1'(r_width);
        end
        if (32'(r_height) < MIN_DIM) begin
            o_cfg.height = HEIGHT_W'(MIN_DIM);
        end else begin
            o_cfg.height = r_height;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rsh_win.sv
// ----------------------------------------------------------------------------
// rsh_win
// 3x3 window registers and laplacian sharpen of the centre pixel
// ----------------------------------------------------------------------------
`default_nettype none

module rsh_win (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  rsh_pkg::t_ctl       i_ctl,
    input  rsh_pkg::t_pix       i_up,
    input  rsh_pkg::t_pix       i_lo,
    input  rsh_pkg::t_pix       i_px,
    output rsh_pkg::t_res       o_res
);
    import rsh_pkg::*;

    t_pix        r_win [3][3];
    t_ctl        r_ctl;
    logic [11:0] sum [3];
    t_pix        sharp;

    function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [11:0] s);
        logic [11:0]        c10;
        logic signed [12:0] acc;
        c10 = {1'b0, c, 3'b000} + {3'b000, c, 1'b0};
        acc = $signed({1'b0, c10}) - $signed({1'b0, s});
        if (acc < 0) begin
            return 8'd0;
        end else if (acc > 13'sd255) begin
            return 8'd255;
        end
        return acc[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            r_ctl <= '0;
        end else if (i_adv) begin
            if (i_ctl.valid) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= i_up;
                r_win[1][2] <= i_lo;
                r_win[2][2] <= i_px;
            end
            r_ctl.valid    <= i_ctl.valid && i_ctl.emit;
            r_ctl.emit     <= i_ctl.emit;
            r_ctl.interior <= i_ctl.interior;
            r_ctl.last     <= i_ctl.last;
        end
    end

    // 9*centre - neighbours == 10*centre - sum of all nine
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    sum[ch] = sum[ch] + 12'(r_win[i][j][8*ch +: 8]);
                end
            end
            sharp[8*ch +: 8] = sharpen(r_win[1][1][8*ch +: 8], sum[ch]);
        end
    end

    assign o_res.valid = r_ctl.valid;
    assign o_res.last  = r_ctl.last;
    assign o_res.rgb   = r_ctl.interior ? sharp : r_win[1][1];

endmodule

`default_nettype wire

FILE: hdl/rgb_sharpen_3x3_unit.sv
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_unit
// streaming 3x3 laplacian sharpen of rgb pixels using two line-store rams
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata rgb, tuser drain flag
//  m_axis    out  tvalid/tready             tdata rgb, tlast frame end
//  apb       in   psel/penable, pready=1    width @0x0, height @0x4
//
//  one word per cycle unless stalled; results reach m_axis after the word that
//  completes its window is taken: ram read at the take, window stage, output reg
//  a stalled m_axis holds the whole pipe and drops s_axis_tready
//  synchronous active-low reset clears counters, window and valids and loads
//  the default geometry; line stores are not cleared, no startup pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_sharpen_3x3_unit_assert.svh"

module rgb_sharpen_3x3_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // red, green, blue
    input  wire logic                        s_axis_tuser,  // kind (1 = drain)
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [23:0]                 m_axis_tdata,  // red, green, blue
    output logic                             m_axis_tlast,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rsh_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rsh_pkg::APB_DW-1:0]  pwdata,
    output logic      [rsh_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import rsh_pkg::*;

    localparam logic [1:0] ROW_ZERO = 2'd0;
    localparam logic [1:0] ROW_ONE  = 2'd1;
    localparam logic [1:0] ROW_MANY = 2'd2;

    t_cfg                cfg;
    logic                adv;
    logic                accept;

    logic [COL_W-1:0]    r_in_col, n_in_col;
    logic [1:0]          r_in_row, n_in_row;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [HEIGHT_W-1:0] r_out_row, n_out_row;

    logic [COL_W-1:0]    ic;
    logic [COL_W:0]      ic_inc;
    logic [COL_W-1:0]    oc;
    logic [COL_W:0]      oc_inc;
    logic [COL_W:0]      w_m1;
    logic [HEIGHT_W-1:0] h_m1;
    t_ctl                ctl;

    t_ctl                r_s2;
    logic [COL_W-1:0]    r_s2_col;
    t_pix                r_s2_px;
    logic                r_fwd;
    t_pix                r_fwd_px;

    t_pix                lo_rdata;
    t_pix                up_rdata;
    t_pix                up;
    t_res                res;

    logic                r_m_valid;
    t_pix                r_m_data;
    logic                r_m_last;

    logic                fwd_hit;
    logic                last_hit;
    logic                cnt_zero;

    rsh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv           = !r_m_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // position bookkeeping for the incoming word and the result it releases
    always_comb begin
        ic     = (CW1'(r_in_col) >= cfg.width) ? '0 : r_in_col;
        ic_inc = CW1'(ic) + CW1'(1);
        w_m1   = cfg.width - CW1'(1);
        h_m1   = cfg.height - HEIGHT_W'(1);
        oc     = (CW1'(r_out_col) >= cfg.width) ? w_m1[COL_W-1:0] : r_out_col;
        oc_inc = CW1'(oc) + CW1'(1);

        ctl.valid    = accept;
        ctl.emit     = (r_in_row == ROW_MANY) || (r_in_row == ROW_ONE && ic != '0);
        ctl.interior = (r_out_row != '0) && (r_out_row < h_m1) &&
                       (oc != '0) && (CW1'(oc) < w_m1);
        ctl.last     = (r_out_row >= h_m1) && (CW1'(oc) >= w_m1);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept) begin
            if (ic_inc >= cfg.width) begin
                n_in_col = '0;
                if (r_in_row != ROW_MANY) begin
                    n_in_row = r_in_row + 2'd1;
                end
            end else begin
                n_in_col = ic_inc[COL_W-1:0];
            end
            if (ctl.emit) begin
                if (ctl.last) begin
                    n_in_col  = '0;
                    n_in_row  = ROW_ZERO;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (oc_inc >= cfg.width) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HEIGHT_W'(1);
                end else begin
                    n_out_col = oc_inc[COL_W-1:0];
                end
            end
        end
    end

    assign fwd_hit  = r_s2.valid && (r_s2_col == ic);
    assign last_hit = accept && ctl.emit && ctl.last;
    assign cnt_zero = (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= ROW_ZERO;
            r_out_col <= '0;
            r_out_row <= '0;
            r_s2      <= '0;
            r_fwd     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (adv) begin
                r_s2      <= ctl;
                r_m_valid <= res.valid;
            end
            // upper store is written from the r_s2 stage; catch a read of that entry
            if (accept) begin
                r_fwd <= fwd_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_col <= ic;
            r_s2_px  <= s_axis_tuser ? '0 : s_axis_tdata;
            r_fwd_px <= lo_rdata;
        end
        if (adv) begin
            r_m_data <= res.rgb;
            r_m_last <= res.last;
        end
    end

    rsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_lower (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (ic),
        .i_wdata (s_axis_tuser ? t_pix'(0) : s_axis_tdata),
        .i_re    (accept),
        .i_raddr (ic),
        .o_rdata (lo_rdata)
    );

    rsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_upper (
        .i_clk   (i_clk),
        .i_we    (adv && r_s2.valid),
        .i_waddr (r_s2_col),
        .i_wdata (lo_rdata),
        .i_re    (accept),
        .i_raddr (ic),
        .o_rdata (up_rdata)
    );

    assign up = r_fwd ? r_fwd_px : up_rdata;

    rsh_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (r_s2),
        .i_up    (up),
        .i_lo    (lo_rdata),
        .i_px    (r_s2_px),
        .o_res   (res)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    `RSH_ASSERT_NEXT(a_fwd_same_entry, i_clk, i_rst_n, accept && fwd_hit, r_fwd)
    `RSH_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, last_hit, cnt_zero)
    `RSH_ASSERT_IMPLIES(a_out_from_pipe, i_clk, i_rst_n, $rose(r_m_valid), $past(res.valid))
    `RSH_ASSERT_IMPLIES(a_border_last, i_clk, i_rst_n, r_s2.valid && r_s2.interior, !r_s2.last)

endmodule

`default_nettype wire
